FILE: hdl/assert_macros.svh
// assertion helpers shared by the stencil modules
// each macro checks at the rising edge of clk and is quiet while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/fpls_pkg.sv
`default_nettype none

package fpls_pkg;

    // field widths
    localparam int SAMPLE_W    = 32;
    localparam int IDX_W       = 10;
    localparam int GRID_W_BITS = 11;
    localparam int SCALE_W     = 32;
    localparam int SUM_W       = 36;
    localparam int MAG_W       = 35;
    localparam int HALF_W      = 16;
    localparam int PROD_W      = MAG_W + HALF_W;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;

    // register reset values and limits
    localparam logic [GRID_W_BITS-1:0] GRID_WIDTH_RST = 11'd1024;
    localparam logic [SCALE_W-1:0]     INV_AREA_RST   = 32'h0001_0000;
    localparam int                     MIN_WIDTH      = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL_AREA = 1'b1;

    // centre weight of the stencil is four, applied as a shift
    localparam int CENTER_SHIFT = 2;

    // rounding constant for the Q16.16 product
    localparam logic [HALF_W-1:0] ROUND_HALF = 16'h8000;

    // saturation bounds
    localparam logic [SAMPLE_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [SAMPLE_W-1:0] SAT_NEG = 32'h8000_0000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       frame_start;
    } fpls_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] laplacian_value;
        logic [IDX_W-1:0]           interior_row;
        logic [IDX_W-1:0]           interior_col;
        logic                       last_point;
    } fpls_result_t;

    // position tag of an interior point
    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
    } fpls_pos_t;

    // unscaled stencil sum with its tag
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        fpls_pos_t               pos;
    } fpls_sum_t;

endpackage

`default_nettype wire

FILE: hdl/five_point_laplacian_stencil_top.sv
// five-point laplacian over a streamed square grid, one sample beat per cycle while item_ready is high
// path: the beat that completes the stencil passes the read, sum, magnitude, product and output registers
// throughput: one sample per cycle unless the output stalls; two line buffer memories are read on accept and
// written when the read stage moves on, with forwarding when the same column comes back at once
// reset: counters, window and config return to defaults; line buffers are not cleared
`default_nettype none

module five_point_laplacian_stencil_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  fpls_pkg::fpls_item_t               item,
    output logic                               result_valid,
    input  logic                               result_ready,
    output fpls_pkg::fpls_result_t             result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fpls_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fpls_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import fpls_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = (AW + 1 > GRID_W_BITS) ? AW + 1 : GRID_W_BITS;

    logic [GRID_W_BITS-1:0] grid_width_reg;
    logic [SCALE_W-1:0]     inv_area_reg;
    logic [WW-1:0]          gw_ext, w_eff;
    logic                   acc;
    logic [AW-1:0]          addr;
    logic                   hit;
    fpls_pos_t              pos;
    logic                   sum_valid, sum_ready;
    fpls_sum_t              sum_bus;

    assign cfg_ready = 1'b1;
    assign acc       = item_valid && item_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg <= GRID_WIDTH_RST;
            inv_area_reg   <= INV_AREA_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_GRID_WIDTH:    grid_width_reg <= cfg_data[GRID_W_BITS-1:0];
                CFG_INV_CELL_AREA: inv_area_reg   <= cfg_data[SCALE_W-1:0];
                default:           ;
            endcase
        end
    end

    // clamp the grid width to the supported range
    always_comb
    begin
        gw_ext = WW'(grid_width_reg);
        if (gw_ext < WW'(MIN_WIDTH))
        begin
            w_eff = WW'(MIN_WIDTH);
        end
        else if (gw_ext > WW'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = gw_ext;
        end
    end

    fpls_ctrl #(.AW(AW), .WW(WW)) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .acc         (acc),
        .frame_start (item.frame_start),
        .w_eff       (w_eff),
        .addr        (addr),
        .hit         (hit),
        .pos         (pos)
    );

    fpls_window #(.MAX_WIDTH(MAX_WIDTH), .AW(AW)) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .acc        (acc),
        .item       (item),
        .addr       (addr),
        .hit        (hit),
        .pos        (pos),
        .item_ready (item_ready),
        .sum_valid  (sum_valid),
        .sum_ready  (sum_ready),
        .sum_out    (sum_bus)
    );

    fpls_scale u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .sum_valid    (sum_valid),
        .sum_ready    (sum_ready),
        .sum_in       (sum_bus),
        .scale        (inv_area_reg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

FILE: hdl/fpls_ram.sv
`default_nettype none

module fpls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/fpls_ctrl.sv
`default_nettype none
`include "assert_macros.svh"

module fpls_ctrl #(
    parameter int AW        = 10,
    parameter int WW        = 11
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              acc,
    input  logic              frame_start,
    input  logic [WW-1:0]     w_eff,
    output logic [AW-1:0]     addr,
    output logic              hit,
    output fpls_pkg::fpls_pos_t pos
);

    import fpls_pkg::*;

    logic [AW-1:0] row_reg, row_next;
    logic [AW-1:0] col_reg, col_next;
    logic [WW-1:0] r_ext, c_ext;
    logic [AW-1:0] r_cur, c_cur;

    // position of the sample in this beat
    always_comb
    begin
        r_cur = frame_start ? '0 : row_reg;
        c_cur = frame_start ? '0 : col_reg;
        r_ext = WW'(r_cur);
        c_ext = WW'(c_cur);
        addr  = c_cur;
        hit   = (r_ext >= WW'(2)) && (c_ext >= WW'(2)) && (r_ext < w_eff) && (c_ext < w_eff);
        pos.row  = IDX_W'(r_ext - WW'(2));
        pos.col  = IDX_W'(c_ext - WW'(2));
        pos.last = (r_ext == w_eff - WW'(1)) && (c_ext == w_eff - WW'(1));
    end

    // raster advance with wrap at the grid edge
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (acc)
        begin
            if (c_ext + WW'(1) >= w_eff)
            begin
                col_next = '0;
                row_next = (r_ext + WW'(1) >= w_eff) ? '0 : AW'(r_ext + WW'(1));
            end
            else
            begin
                col_next = AW'(c_ext + WW'(1));
                row_next = r_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    `ASSERT_NEXT(a_wrap_after_last, acc && hit && pos.last, row_reg == '0 && col_reg == '0, "position did not wrap after last point")

endmodule

`default_nettype wire

FILE: hdl/fpls_window.sv
`default_nettype none
`include "assert_macros.svh"

module fpls_window #(
    parameter int MAX_WIDTH = 1024,
    parameter int AW        = 10
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    acc,
    input  fpls_pkg::fpls_item_t    item,
    input  logic [AW-1:0]           addr,
    input  logic                    hit,
    input  fpls_pkg::fpls_pos_t     pos,
    output logic                    item_ready,
    output logic                    sum_valid,
    input  logic                    sum_ready,
    output fpls_pkg::fpls_sum_t     sum_out
);

    import fpls_pkg::*;

    // line buffer read stage
    logic                v1_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic [AW-1:0]       s1_addr_reg;
    logic                s1_hit_reg;
    fpls_pos_t           s1_pos_reg;
    logic                fwd_reg;
    logic [SAMPLE_W-1:0] fwd_prev_reg;
    logic [SAMPLE_W-1:0] fwd_second_reg;

    // neighbour holding registers
    logic [SAMPLE_W-1:0] win_a_reg;
    logic [SAMPLE_W-1:0] win_b_reg;
    logic [SAMPLE_W-1:0] up_hold_reg;
    logic [SAMPLE_W-1:0] down_hold_reg;

    // sum stage
    logic                v2_reg;
    fpls_sum_t           s2_reg;

    logic [SAMPLE_W-1:0] prev_rd, second_rd;
    logic [SAMPLE_W-1:0] p_val, q_val;
    logic                rdy2, s1_fire;
    logic signed [SUM_W-1:0] sum_calc;

    fpls_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WIDTH)) u_prev_row (
        .clk   (clk),
        .we    (s1_fire),
        .waddr (s1_addr_reg),
        .wdata (s1_sample_reg),
        .re    (acc),
        .raddr (addr),
        .rdata (prev_rd)
    );

    fpls_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WIDTH)) u_second_row (
        .clk   (clk),
        .we    (s1_fire),
        .waddr (s1_addr_reg),
        .wdata (p_val),
        .re    (acc),
        .raddr (addr),
        .rdata (second_rd)
    );

    // handshake between stages
    assign rdy2       = !v2_reg || sum_ready;
    assign s1_fire    = v1_reg && rdy2;
    assign item_ready = !v1_reg || rdy2;
    assign sum_valid  = v2_reg;
    assign sum_out    = s2_reg;

    // forward the pending write when the same column is read back at once
    assign p_val = fwd_reg ? fwd_prev_reg   : prev_rd;
    assign q_val = fwd_reg ? fwd_second_reg : second_rd;

    // four neighbours minus four times the centre
    assign sum_calc = SUM_W'($signed(up_hold_reg)) + SUM_W'($signed(down_hold_reg))
                    + SUM_W'($signed(win_a_reg)) + SUM_W'($signed(p_val))
                    - (SUM_W'($signed(win_b_reg)) <<< CENTER_SHIFT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            fwd_reg       <= 1'b0;
            v2_reg        <= 1'b0;
            win_a_reg     <= '0;
            win_b_reg     <= '0;
            up_hold_reg   <= '0;
            down_hold_reg <= '0;
        end
        else
        begin
            if (acc)
            begin
                v1_reg  <= 1'b1;
                fwd_reg <= s1_fire && (addr == s1_addr_reg);
            end
            else if (s1_fire)
            begin
                v1_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                win_a_reg     <= win_b_reg;
                win_b_reg     <= p_val;
                up_hold_reg   <= q_val;
                down_hold_reg <= s1_sample_reg;
            end
            if (rdy2)
            begin
                v2_reg <= s1_fire && s1_hit_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_sample_reg  <= item.sample;
            s1_addr_reg    <= addr;
            s1_hit_reg     <= hit;
            s1_pos_reg     <= pos;
            fwd_prev_reg   <= s1_sample_reg;
            fwd_second_reg <= p_val;
        end
        if (s1_fire && rdy2)
        begin
            s2_reg.sum <= sum_calc;
            s2_reg.pos <= s1_pos_reg;
        end
    end

    `ASSERT_SAME(a_no_overwrite, v1_reg && !rdy2, !acc, "read stage overwritten while held")
    `ASSERT_NEXT(a_hit_reaches_sum, s1_fire && s1_hit_reg, v2_reg, "interior point lost at sum stage")

endmodule

`default_nettype wire

FILE: hdl/fpls_scale.sv
`default_nettype none
`include "assert_macros.svh"

module fpls_scale (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sum_valid,
    output logic                              sum_ready,
    input  fpls_pkg::fpls_sum_t               sum_in,
    input  logic [fpls_pkg::SCALE_W-1:0]      scale,
    output logic                              result_valid,
    input  logic                              result_ready,
    output fpls_pkg::fpls_result_t            result
);

    import fpls_pkg::*;

    // magnitude stage
    logic             v3_reg;
    logic             s3_neg_reg;
    logic [MAG_W-1:0] s3_mag_reg;
    fpls_pos_t        s3_pos_reg;

    // partial product stage
    logic              v4_reg;
    logic              s4_neg_reg;
    logic [PROD_W-1:0] s4_hi_reg;
    logic [PROD_W-1:0] s4_lo_reg;
    fpls_pos_t         s4_pos_reg;

    // output register
    logic         vo_reg;
    fpls_result_t out_reg;

    logic rdy_o, rdy4, rdy3;
    logic load3, load4, load_o;
    logic signed [SUM_W-1:0] mag_full;
    logic [PROD_W:0]         lo_round;
    logic [PROD_W:0]         prod_sum;
    logic [SAMPLE_W-1:0]     sat_val;

    assign rdy_o     = !vo_reg || result_ready;
    assign rdy4      = !v4_reg || rdy_o;
    assign rdy3      = !v3_reg || rdy4;
    assign sum_ready = rdy3;
    assign load3     = sum_valid && rdy3;
    assign load4     = v3_reg && rdy4;
    assign load_o    = v4_reg && rdy_o;

    assign result_valid = vo_reg;
    assign result       = out_reg;

    // absolute value of the sum
    assign mag_full = (sum_in.sum < 0) ? -sum_in.sum : sum_in.sum;

    // recombine partial products, round half away from zero, saturate
    always_comb
    begin
        lo_round = {1'b0, s4_lo_reg} + (PROD_W + 1)'(ROUND_HALF);
        prod_sum = {1'b0, s4_hi_reg} + (PROD_W + 1)'(lo_round[PROD_W:HALF_W]);
        if (s4_neg_reg)
        begin
            if (prod_sum >= (PROD_W + 1)'(SAT_NEG))
            begin
                sat_val = SAT_NEG;
            end
            else
            begin
                sat_val = '0 - prod_sum[SAMPLE_W-1:0];
            end
        end
        else
        begin
            if (prod_sum > (PROD_W + 1)'(SAT_POS))
            begin
                sat_val = SAT_POS;
            end
            else
            begin
                sat_val = prod_sum[SAMPLE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (rdy3)
            begin
                v3_reg <= sum_valid;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (rdy_o)
            begin
                vo_reg <= v4_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (load3)
        begin
            s3_neg_reg <= sum_in.sum < 0;
            s3_mag_reg <= MAG_W'(mag_full);
            s3_pos_reg <= sum_in.pos;
        end
        if (load4)
        begin
            s4_neg_reg <= s3_neg_reg;
            s4_hi_reg  <= PROD_W'(s3_mag_reg) * PROD_W'(scale[SCALE_W-1:HALF_W]);
            s4_lo_reg  <= PROD_W'(s3_mag_reg) * PROD_W'(scale[HALF_W-1:0]);
            s4_pos_reg <= s3_pos_reg;
        end
        if (load_o)
        begin
            out_reg.laplacian_value <= sat_val;
            out_reg.interior_row    <= s4_pos_reg.row;
            out_reg.interior_col    <= s4_pos_reg.col;
            out_reg.last_point      <= s4_pos_reg.last;
        end
    end

    `ASSERT_NEXT(a_product_held, v4_reg && !rdy_o, v4_reg, "product stage dropped under stall")
    `ASSERT_SAME(a_zero_mag_zero_out, load_o && s4_hi_reg == '0 && s4_lo_reg == '0, sat_val == '0, "zero product gave nonzero result")

endmodule

`default_nettype wire
